@@ src/mls_pkg.sv @@
// ============================================================================
// mls_pkg: shared types for the marked LIFO stack
// Operation and status codes, and the control bundle that the decode logic
// hands to the top level.
// ============================================================================
`default_nettype none

package mls_pkg;

    // Operation codes carried by each input item.
    typedef enum logic [2:0] {
        OP_PUSH    = 3'd0,
        OP_POP     = 3'd1,
        OP_PEEK    = 3'd2,
        OP_READ_AT = 3'd3,
        OP_WRITE_AT = 3'd4,
        OP_CLEAR   = 3'd5,
        OP_CUT     = 3'd6,
        OP_RESERVE = 3'd7
    } op_t;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_OVERFLOW = 2'd1,
        ST_UNDERFLOW = 2'd2,
        ST_RANGE    = 2'd3
    } status_t;

    // Decode result for one operation.
    typedef struct packed {
        logic    wr_en;
        logic    rd_en;
        logic    is_empty;
        logic    is_full;
        status_t status;
    } ctl_t;

    // Fixed field widths of the result.
    localparam int unsigned IDX_W = 9;

endpackage

`default_nettype wire

@@ src/mls_ctrl.sv @@
// ============================================================================
// mls_ctrl: operation decode for the marked LIFO stack
// Checks bounds, picks the store address, and computes the next fill level
// and flags for one operation against the current state.
// ============================================================================
`default_nettype none

module mls_ctrl #(
    parameter int unsigned DEPTH = 256
) (
    input  wire logic [2:0]                   operation,
    input  wire logic [7:0]                   mark,
    input  wire logic [8:0]                   offset,
    input  wire logic [8:0]                   slot_count,
    input  wire logic [8:0]                   capacity,
    input  wire logic [$clog2(DEPTH+1)-1:0]   fill_level,
    output logic [$clog2(DEPTH+1)-1:0]        fill_next,
    output logic [$clog2(DEPTH)-1:0]          addr,
    output mls_pkg::ctl_t                     ctl
);
    import mls_pkg::*;

    localparam int unsigned FILL_W = $clog2(DEPTH + 1);
    localparam int unsigned ADDR_W = $clog2(DEPTH);
    localparam int unsigned CW     = ((FILL_W > 9) ? FILL_W : 9) + 1;

    logic [CW-1:0] fill_w;
    logic [CW-1:0] fill_nx_w;
    logic [CW-1:0] cap_raw;
    logic [CW-1:0] cap_w;
    logic [CW-1:0] mark_w;
    logic [CW-1:0] pos_w;
    logic [CW-1:0] fill_m1;
    logic [CW-1:0] reserve_sum;
    logic [9:0]    pos10;
    logic          pos_ok;
    status_t       status;
    logic          wr_en;
    logic          rd_en;

    // Widen operands and clamp the capacity to the range one to DEPTH.
    always_comb
    begin
        fill_w      = CW'(fill_level);
        mark_w      = CW'(mark);
        cap_raw     = CW'(capacity);
        fill_m1     = fill_w - CW'(1);
        reserve_sum = fill_w + CW'(slot_count);
        if (cap_raw == '0)
        begin
            cap_w = CW'(1);
        end
        else if (cap_raw > CW'(DEPTH))
        begin
            cap_w = CW'(DEPTH);
        end
        else
        begin
            cap_w = cap_raw;
        end
    end

    // Position for read at and write at: mark and mark plus offset must both
    // lie in the filled part, and the sum must not be negative.
    always_comb
    begin
        pos10  = {2'b00, mark} + {offset[8], offset};
        pos_w  = CW'(pos10[8:0]);
        pos_ok = (mark_w < fill_w) && !pos10[9] && (pos_w < fill_w);
    end

    // Per-operation decode.
    always_comb
    begin
        fill_nx_w = fill_w;
        addr      = '0;
        status    = ST_OK;
        wr_en     = 1'b0;
        rd_en     = 1'b0;
        case (op_t'(operation))
            OP_PUSH:
            begin
                if (fill_w >= cap_w)
                begin
                    status = ST_OVERFLOW;
                end
                else
                begin
                    wr_en     = 1'b1;
                    addr      = fill_w[ADDR_W-1:0];
                    fill_nx_w = fill_w + CW'(1);
                end
            end
            OP_POP:
            begin
                if (fill_w == '0)
                begin
                    status = ST_UNDERFLOW;
                end
                else
                begin
                    rd_en     = 1'b1;
                    addr      = fill_m1[ADDR_W-1:0];
                    fill_nx_w = fill_m1;
                end
            end
            OP_PEEK:
            begin
                if (fill_w == '0)
                begin
                    status = ST_UNDERFLOW;
                end
                else
                begin
                    rd_en = 1'b1;
                    addr  = fill_m1[ADDR_W-1:0];
                end
            end
            OP_READ_AT:
            begin
                if (pos_ok)
                begin
                    rd_en = 1'b1;
                    addr  = pos_w[ADDR_W-1:0];
                end
                else
                begin
                    status = ST_RANGE;
                end
            end
            OP_WRITE_AT:
            begin
                if (pos_ok)
                begin
                    wr_en = 1'b1;
                    addr  = pos_w[ADDR_W-1:0];
                end
                else
                begin
                    status = ST_RANGE;
                end
            end
            OP_CLEAR:
            begin
                fill_nx_w = '0;
            end
            OP_CUT:
            begin
                if (mark_w < fill_w)
                begin
                    fill_nx_w = mark_w;
                end
                else
                begin
                    status = ST_RANGE;
                end
            end
            OP_RESERVE:
            begin
                if ((slot_count != '0) && (reserve_sum > cap_w))
                begin
                    status = ST_OVERFLOW;
                end
                else
                begin
                    fill_nx_w = reserve_sum;
                end
            end
            default:
            begin
                status = ST_OK;
            end
        endcase
    end

    // Outputs and flags after the operation.
    assign fill_next    = fill_nx_w[FILL_W-1:0];
    assign ctl.wr_en    = wr_en;
    assign ctl.rd_en    = rd_en;
    assign ctl.status   = status;
    assign ctl.is_empty = (fill_nx_w == '0);
    assign ctl.is_full  = (fill_nx_w >= cap_w);

endmodule

`default_nettype wire

@@ src/mls_mem.sv @@
// ============================================================================
// mls_mem: entry store of the marked LIFO stack
// One write port and one registered read port. After reset a clearing pass
// writes zero to every entry, one entry per cycle, while busy is high.
// ============================================================================
`default_nettype none

module mls_mem #(
    parameter int unsigned DEPTH      = 256,
    parameter int unsigned WORD_WIDTH = 32
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       wr_en,
    input  wire logic [$clog2(DEPTH)-1:0]   wr_addr,
    input  wire logic [WORD_WIDTH-1:0]      wr_data,
    input  wire logic                       rd_en,
    input  wire logic [$clog2(DEPTH)-1:0]   rd_addr,
    output logic [WORD_WIDTH-1:0]           rd_data,
    output logic                            busy
);
    localparam int unsigned ADDR_W = $clog2(DEPTH);

    logic [WORD_WIDTH-1:0] mem [DEPTH];
    logic [ADDR_W-1:0]     clr_addr_reg;
    logic [ADDR_W-1:0]     clr_addr_next;
    logic                  busy_reg;
    logic                  busy_next;
    logic [WORD_WIDTH-1:0] rd_data_reg;

    // Clearing pass sequencing.
    always_comb
    begin
        clr_addr_next = clr_addr_reg;
        busy_next     = busy_reg;
        if (busy_reg)
        begin
            if (clr_addr_reg == ADDR_W'(DEPTH - 1))
            begin
                busy_next = 1'b0;
            end
            else
            begin
                clr_addr_next = clr_addr_reg + ADDR_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
            busy_reg     <= 1'b1;
        end
        else
        begin
            clr_addr_reg <= clr_addr_next;
            busy_reg     <= busy_next;
        end
    end

    // Storage array: clearing writes take the port while busy.
    always_ff @(posedge clk)
    begin
        if (busy_reg)
        begin
            mem[clr_addr_reg] <= '0;
        end
        else if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read; the data holds until the next read.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
    assign busy    = busy_reg;

endmodule

`default_nettype wire

@@ src/marked_lifo_stack_unit.sv @@
// ============================================================================
// marked_lifo_stack_unit: LIFO stack with marked access
// Top level: input and result channels, capacity register, fill level and
// the result register.
// ============================================================================
//
// Usage:
//   Items enter on the in_valid/in_ready channel; each names one operation
//   (push, pop, peek, read at, write at, clear, cut to mark, reserve).
//   Every item gives exactly one result on out_valid/out_ready.
//   The result of an item is registered and shown from the cycle after
//   its transfer. Throughput is one item per cycle while out_ready stays high,
//   set by the combinational decode and the one-write, one-read store port.
//   When the receiver stalls, the result holds and in_ready drops until
//   the result is transferred; in_ready follows out_ready in the same cycle.
//   The capacity register is written by cfg_wr_en/cfg_wr_data and takes
//   effect for the next item; it resets to 256.
//   After reset the store is cleared one entry per cycle, and in_ready stays
//   low during that pass. The fill level resets to zero and no result is pending.
//
`default_nettype none

module marked_lifo_stack_unit #(
    parameter int unsigned DEPTH      = 256,
    parameter int unsigned WORD_WIDTH = 32
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_wr_en,
    input  wire logic [8:0]             cfg_wr_data,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic [2:0]             operation,
    input  wire logic [WORD_WIDTH-1:0]  item_value,
    input  wire logic [7:0]             mark,
    input  wire logic [8:0]             offset,
    input  wire logic [8:0]             slot_count,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic [WORD_WIDTH-1:0]       item_out,
    output logic [8:0]                  top_index,
    output logic [8:0]                  reserve_base,
    output logic [1:0]                  status,
    output logic                        is_empty,
    output logic                        is_full
);
    import mls_pkg::*;

    localparam int unsigned FILL_W = $clog2(DEPTH + 1);
    localparam int unsigned ADDR_W = $clog2(DEPTH);
    localparam int unsigned CW     = ((FILL_W > IDX_W) ? FILL_W : IDX_W) + 1;

    logic [8:0]        capacity_reg;
    logic [FILL_W-1:0] fill_level_reg;
    logic [FILL_W-1:0] fill_next;
    logic [ADDR_W-1:0] addr;
    ctl_t              ctl;
    logic              busy;
    logic              in_xfer;
    logic [WORD_WIDTH-1:0] rd_data;
    logic [CW-1:0]     fill_before_w;
    logic [CW-1:0]     top_w;

    logic              out_valid_reg;
    logic              rd_ok_reg;
    logic [8:0]        top_index_reg;
    logic [8:0]        reserve_base_reg;
    status_t           status_reg;
    logic              is_empty_reg;
    logic              is_full_reg;

    // Handshake: take an item when the store is not clearing and the result slot is free or drains now.
    assign in_ready = !busy && (!out_valid_reg || out_ready);
    assign in_xfer  = in_valid && in_ready;

    // Operation decode.
    mls_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .operation  (operation),
        .mark       (mark),
        .offset     (offset),
        .slot_count (slot_count),
        .capacity   (capacity_reg),
        .fill_level (fill_level_reg),
        .fill_next  (fill_next),
        .addr       (addr),
        .ctl        (ctl)
    );

    // Entry store.
    mls_mem #(
        .DEPTH      (DEPTH),
        .WORD_WIDTH (WORD_WIDTH)
    ) u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (in_xfer && ctl.wr_en),
        .wr_addr (addr),
        .wr_data (item_value),
        .rd_en   (in_xfer && ctl.rd_en),
        .rd_addr (addr),
        .rd_data (rd_data),
        .busy    (busy)
    );

    // Result index fields.
    assign fill_before_w = CW'(fill_level_reg);
    assign top_w         = CW'(fill_next) - CW'(1);

    // Capacity register and fill level.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg   <= 9'd256;
            fill_level_reg <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                capacity_reg <= cfg_wr_data;
            end
            if (in_xfer)
            begin
                fill_level_reg <= fill_next;
            end
        end
    end

    // Result register control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_xfer)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result register payload.
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            rd_ok_reg        <= ctl.rd_en;
            top_index_reg    <= top_w[8:0];
            reserve_base_reg <= fill_before_w[8:0];
            status_reg       <= ctl.status;
            is_empty_reg     <= ctl.is_empty;
            is_full_reg      <= ctl.is_full;
        end
    end

    assign out_valid    = out_valid_reg;
    assign item_out     = rd_ok_reg ? rd_data : '0;
    assign top_index    = top_index_reg;
    assign reserve_base = reserve_base_reg;
    assign status       = status_reg;
    assign is_empty     = is_empty_reg;
    assign is_full      = is_full_reg;

    // No item is taken during the clearing pass.
    a_no_take_while_clearing : assert property (
        @(posedge clk) disable iff (!rst_n) busy |-> !in_ready
    ) else $error("item taken during clearing pass");

    // One operation never both reads and writes the store.
    a_single_access : assert property (
        @(posedge clk) disable iff (!rst_n) !(ctl.wr_en && ctl.rd_en)
    ) else $error("operation both reads and writes the store");

    // A failed operation leaves the fill level unchanged.
    a_fail_keeps_fill : assert property (
        @(posedge clk) disable iff (!rst_n)
        (in_xfer && (ctl.status != ST_OK)) |=> $stable(fill_level_reg)
    ) else $error("failed operation changed the fill level");

    // The fill level never exceeds the built depth.
    a_fill_bounded : assert property (
        @(posedge clk) disable iff (!rst_n) fill_level_reg <= FILL_W'(DEPTH)
    ) else $error("fill level above depth");

    // Empty flag agrees with the top index of the same result.
    a_empty_matches_top : assert property (
        @(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (is_empty_reg == (top_index_reg == 9'h1FF))
    ) else $error("empty flag disagrees with top index");

endmodule

`default_nettype wire
